[src/vtpd_pkg.sv]
`timescale 1ns / 1ps
package vtpd_pkg;
  localparam int unsigned FracBitsDef = 16;
  localparam int unsigned ElemW = 32;
  localparam int unsigned ProdW = 64;
  localparam int unsigned SumW = 66;
  localparam int unsigned NumRegs = 8;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 64;
  localparam int unsigned NumW = ElemW + 24;
  localparam int unsigned QuoW = NumW;
  localparam logic [ElemW-1:0] SatMax = 32'h7fffffff;
  localparam logic [ElemW-1:0] SatMin = 32'h80000000;

  typedef enum logic {
    REQ_POINT = 1'b0,
    REQ_DIR   = 1'b1
  } req_t;

  typedef struct packed {
    logic valid;
    logic dir;
  } ctl_t;

  function automatic logic [ElemW-1:0] sat_sum(input logic signed [SumW-1:0] s);
    if (s > $signed({{(SumW-ElemW){1'b0}}, SatMax})) begin
      return SatMax;
    end else if (s < $signed({{(SumW-ElemW){1'b1}}, SatMin})) begin
      return SatMin;
    end
    return s[ElemW-1:0];
  endfunction
endpackage

[src/vtpd_lane.sv]
`timescale 1ns / 1ps
module vtpd_lane
  import vtpd_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FracBitsDef
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic                    in_dir,
  input  logic signed [ElemW-1:0] v0,
  input  logic signed [ElemW-1:0] v1,
  input  logic signed [ElemW-1:0] v2,
  input  logic signed [ElemW-1:0] v3,
  input  logic signed [ElemW-1:0] m0,
  input  logic signed [ElemW-1:0] m1,
  input  logic signed [ElemW-1:0] m2,
  input  logic signed [ElemW-1:0] m3,
  output logic                    out_valid,
  output logic signed [ElemW-1:0] out_sum
);
  logic signed [ProdW-1:0] p_r [4];
  logic signed [SumW-1:0] s_nxt, s_r;
  logic [1:0] vld_r;
  logic signed [SumW-1:0] sh;

  always_ff @(posedge clk) begin
    p_r[0] <= m0 * v0;
    p_r[1] <= m1 * v1;
    p_r[2] <= m2 * v2;
    p_r[3] <= in_dir ? $signed(ProdW'(0)) : m3 * v3;
    s_r <= s_nxt;
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[0], in_valid};
    end
  end

  always_comb begin
    s_nxt = SumW'(p_r[0]) + SumW'(p_r[1]) + SumW'(p_r[2]) + SumW'(p_r[3]);
    sh = s_r >>> FRAC_BITS;
  end

  assign out_valid = vld_r[1];
  assign out_sum = sat_sum(sh);
endmodule

[src/vtpd_div.sv]
`timescale 1ns / 1ps
module vtpd_div
  import vtpd_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FracBitsDef
) (
  input  logic                    clk,
  input  logic signed [ElemW-1:0] num,
  input  logic signed [ElemW-1:0] den,
  output logic signed [ElemW-1:0] quo
);
  localparam int unsigned Steps = ElemW + FRAC_BITS;
  localparam int unsigned AW = ElemW + FRAC_BITS;
  logic [AW-1:0] n_r [Steps+1];
  logic [AW-1:0] q_r [Steps+1];
  logic [ElemW:0] r_r [Steps+1];
  logic [ElemW-1:0] d_r [Steps+1];
  logic neg_r [Steps+1];
  logic [ElemW:0] rt [Steps];
  logic [ElemW:0] df [Steps];
  logic [AW:0] qs;

  always_comb begin
    n_r[0] = {(num[ElemW-1] ? ElemW'(-num) : ElemW'(num)), {FRAC_BITS{1'b0}}};
    d_r[0] = den[ElemW-1] ? ElemW'(-den) : ElemW'(den);
    neg_r[0] = num[ElemW-1] ^ den[ElemW-1];
    q_r[0] = '0;
    r_r[0] = '0;
  end

  for (genvar i = 0; i < Steps; i++) begin : g_st
    always_comb begin
      rt[i] = {r_r[i][ElemW-1:0], n_r[i][AW-1]};
      df[i] = rt[i] - {1'b0, d_r[i]};
    end
    always_ff @(posedge clk) begin
      n_r[i+1] <= {n_r[i][AW-2:0], 1'b0};
      d_r[i+1] <= d_r[i];
      neg_r[i+1] <= neg_r[i];
      if (!df[i][ElemW]) begin
        r_r[i+1] <= df[i];
        q_r[i+1] <= {q_r[i][AW-2:0], 1'b1};
      end else begin
        r_r[i+1] <= rt[i];
        q_r[i+1] <= {q_r[i][AW-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    qs = neg_r[Steps] ? -{1'b0, q_r[Steps]} : {1'b0, q_r[Steps]};
    if ($signed(qs) > $signed({{(AW+1-ElemW){1'b0}}, SatMax})) begin
      quo = SatMax;
    end else if ($signed(qs) < $signed({{(AW+1-ElemW){1'b1}}, SatMin})) begin
      quo = SatMin;
    end else begin
      quo = qs[ElemW-1:0];
    end
  end
endmodule

[src/vertex_transform_persp_divide.sv]
`timescale 1ns / 1ps
// Four multiply-accumulate lanes compute the row sums of one vertex in two
// register stages, then three pipelined restoring dividers of 32 + FRAC_BITS stages
// divide x, y and z by w for point requests. A vertex is taken every cycle whenever
// busy is low, and busy stays low, so the result for each request appears on the
// out_ ports, marked by out_valid, once it has passed the lane registers and the
// divider stages. The receiver cannot stall, so it must take every result in the
// cycle it shows.
module vertex_transform_persp_divide
  import vtpd_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FracBitsDef
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic                    in_req_type,
  input  logic signed [ElemW-1:0] in_x,
  input  logic signed [ElemW-1:0] in_y,
  input  logic signed [ElemW-1:0] in_z,
  input  logic signed [ElemW-1:0] in_w,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CfgIdxW-1:0]      cfg_index,
  input  logic [CfgDataW-1:0]     cfg_data,
  output logic                    out_valid,
  output logic signed [ElemW-1:0] out_x,
  output logic signed [ElemW-1:0] out_y,
  output logic signed [ElemW-1:0] out_z,
  output logic signed [ElemW-1:0] out_w,
  output logic                    out_div_by_zero
);
  localparam int unsigned DivLat = ElemW + FRAC_BITS;
  localparam logic [ElemW-1:0] One = ElemW'(1) << FRAC_BITS;

  logic [CfgDataW-1:0] m_r [NumRegs];
  logic [ElemW-1:0] vw;
  logic [3:0] lv;
  logic signed [ElemW-1:0] rs [4];
  logic signed [ElemW-1:0] q [3];
  logic signed [ElemW-1:0] dq;
  ctl_t ctl_r [DivLat+1];
  ctl_t ctl_nxt;
  logic dz_r [DivLat+1];
  logic signed [ElemW-1:0] d_r [3][DivLat+1];

  assign busy = 1'b0;
  assign cfg_ready = 1'b1;
  assign vw = (in_req_type == REQ_DIR) ? '0 : in_w;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_r[0] <= CfgDataW'(One);
      m_r[1] <= '0;
      m_r[2] <= {One, {ElemW{1'b0}}};
      m_r[3] <= '0;
      m_r[4] <= '0;
      m_r[5] <= CfgDataW'(One);
      m_r[6] <= '0;
      m_r[7] <= {One, {ElemW{1'b0}}};
    end else if (cfg_valid && cfg_ready) begin
      m_r[cfg_index] <= cfg_data;
    end
  end

  logic dir_d1_r, dir_d2_r;
  always_ff @(posedge clk) begin
    dir_d1_r <= in_req_type;
    dir_d2_r <= dir_d1_r;
  end

  for (genvar r = 0; r < 4; r++) begin : g_lane
    vtpd_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
      .clk(clk), .rst_n(rst_n), .in_valid(start && !busy),
      .in_dir(in_req_type == REQ_DIR),
      .v0(in_x), .v1(in_y), .v2(in_z), .v3(vw),
      .m0(m_r[0 + r/2][(r%2)*ElemW +: ElemW]),
      .m1(m_r[2 + r/2][(r%2)*ElemW +: ElemW]),
      .m2(m_r[4 + r/2][(r%2)*ElemW +: ElemW]),
      .m3(m_r[6 + r/2][(r%2)*ElemW +: ElemW]),
      .out_valid(lv[r]), .out_sum(rs[r])
    );
  end

  assign dq = (rs[3] == '0) ? ElemW'(1) : rs[3];
  for (genvar k = 0; k < 3; k++) begin : g_div
    vtpd_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clk(clk), .num(rs[k]), .den(dq), .quo(q[k])
    );
    always_ff @(posedge clk) begin
      d_r[k][0] <= rs[k];
      for (int i = 0; i < DivLat; i++) d_r[k][i+1] <= d_r[k][i];
    end
  end

  always_comb begin
    ctl_nxt.valid = lv[0] & lv[1] & lv[2] & lv[3];
    ctl_nxt.dir = dir_d2_r;
  end

  always_ff @(posedge clk) begin
    dz_r[0] <= (rs[3] == '0);
    for (int i = 0; i < DivLat; i++) dz_r[i+1] <= dz_r[i];
    if (!rst_n) begin
      for (int i = 0; i <= DivLat; i++) ctl_r[i] <= '0;
    end else begin
      ctl_r[0] <= ctl_nxt;
      for (int i = 0; i < DivLat; i++) ctl_r[i+1] <= ctl_r[i];
    end
  end

  logic last_dir, last_dz;
  always_comb begin
    last_dir = ctl_r[DivLat-1].dir;
    last_dz = dz_r[DivLat-1] && !last_dir;
    out_valid = ctl_r[DivLat-1].valid;
    out_div_by_zero = last_dz;
    out_w = last_dir ? '0 : One;
    if (last_dir) begin
      out_x = d_r[0][DivLat-1];
      out_y = d_r[1][DivLat-1];
      out_z = d_r[2][DivLat-1];
    end else if (last_dz) begin
      out_x = '0;
      out_y = '0;
      out_z = '0;
    end else begin
      out_x = q[0];
      out_y = q[1];
      out_z = q[2];
    end
  end
endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
module tb;
  import vtpd_pkg::*;

  localparam int unsigned LatencyCycles = 33 + FracBitsDef;
  localparam int unsigned CycleLimit = 400000;
  localparam logic signed [ElemW-1:0] OneQ = 32'sd1 <<< FracBitsDef;

  typedef struct packed {
    logic signed [ElemW-1:0] x;
    logic signed [ElemW-1:0] y;
    logic signed [ElemW-1:0] z;
    logic signed [ElemW-1:0] w;
    logic                    dz;
  } vtx_out_t;

  typedef struct {
    logic                    is_cfg;
    logic [CfgIdxW-1:0]      idx;
    logic [CfgDataW-1:0]     data;
    req_t                    kind;
    logic signed [ElemW-1:0] x;
    logic signed [ElemW-1:0] y;
    logic signed [ElemW-1:0] z;
    logic signed [ElemW-1:0] w;
    logic                    has_exp;
    vtx_out_t                exp;
  } stim_row_t;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic in_req_type;
  logic signed [ElemW-1:0] in_x, in_y, in_z, in_w;
  logic cfg_valid;
  logic cfg_ready;
  logic [CfgIdxW-1:0] cfg_index;
  logic [CfgDataW-1:0] cfg_data;
  logic out_valid;
  logic signed [ElemW-1:0] out_x, out_y, out_z, out_w;
  logic out_div_by_zero;

  logic [CfgDataW-1:0] matrix_regs [NumRegs];
  vtx_out_t pending_vtx [$];
  int unsigned mismatches;
  int unsigned n_requests;
  int unsigned n_results;
  int unsigned n_zero_w;
  int unsigned cycles;
  logic idle_gaps;

  vertex_transform_persp_divide u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_req_type    (in_req_type),
    .in_x           (in_x),
    .in_y           (in_y),
    .in_z           (in_z),
    .in_w           (in_w),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .out_valid      (out_valid),
    .out_x          (out_x),
    .out_y          (out_y),
    .out_z          (out_z),
    .out_w          (out_w),
    .out_div_by_zero(out_div_by_zero)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic signed [ElemW-1:0] mat_elem(int row, int col);
    logic [CfgDataW-1:0] r;
    r = matrix_regs[col * 2 + row / 2];
    return (row % 2) ? $signed(r[63:32]) : $signed(r[31:0]);
  endfunction

  function automatic logic signed [ElemW-1:0] clamp32(longint v);
    if (v > 64'sd2147483647) begin
      return SatMax;
    end else if (v < -64'sd2147483648) begin
      return SatMin;
    end
    return v[ElemW-1:0];
  endfunction

  function automatic vtx_out_t transform_vertex(req_t kind, logic signed [ElemW-1:0] x,
                                                logic signed [ElemW-1:0] y,
                                                logic signed [ElemW-1:0] z,
                                                logic signed [ElemW-1:0] w);
    logic signed [ElemW-1:0] v [4];
    logic signed [ElemW-1:0] r [4];
    logic signed [SumW-1:0] acc;
    logic signed [SumW-1:0] prod;
    int terms;
    vtx_out_t res;
    v[0] = x;
    v[1] = y;
    v[2] = z;
    v[3] = w;
    terms = (kind == REQ_DIR) ? 3 : 4;
    for (int row = 0; row < 4; row++) begin
      acc = '0;
      for (int c = 0; c < terms; c++) begin
        prod = SumW'(mat_elem(row, c)) * SumW'(v[c]);
        acc = acc + prod;
      end
      acc = acc >>> FracBitsDef;
      if (acc > 66'sd2147483647) begin
        r[row] = SatMax;
      end else if (acc < -66'sd2147483648) begin
        r[row] = SatMin;
      end else begin
        r[row] = acc[ElemW-1:0];
      end
    end
    res.dz = 1'b0;
    if (kind == REQ_DIR) begin
      res.w = '0;
    end else begin
      res.w = OneQ;
      if (r[3] == 0) begin
        res.dz = 1'b1;
        for (int i = 0; i < 3; i++) r[i] = '0;
      end else begin
        for (int i = 0; i < 3; i++) begin
          r[i] = clamp32((longint'(r[i]) * (64'sd1 <<< FracBitsDef)) / longint'(r[3]));
        end
      end
    end
    res.x = r[0];
    res.y = r[1];
    res.z = r[2];
    return res;
  endfunction

  task automatic drain_pipeline();
    while (pending_vtx.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Leaves cfg_valid high so back-to-back writes never drop it within a step.
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    matrix_regs[idx] = data;
  endtask

  task automatic send_vertex(req_t kind, logic signed [ElemW-1:0] x,
                             logic signed [ElemW-1:0] y, logic signed [ElemW-1:0] z,
                             logic signed [ElemW-1:0] w, logic has_exp, vtx_out_t exp);
    int gap;
    vtx_out_t want;
    gap = idle_gaps ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    want = has_exp ? exp : transform_vertex(kind, x, y, z, w);
    start <= 1'b1;
    in_req_type <= kind;
    in_x <= x;
    in_y <= y;
    in_z <= z;
    in_w <= w;
    do @(posedge clk); while (busy);
    pending_vtx.push_back(want);
    n_requests++;
  endtask

  function automatic logic signed [ElemW-1:0] rand_comp();
    case ($urandom_range(0, 3))
      0: return $signed($urandom());
      1: return $signed(32'($urandom_range(0, 1 << 25)) - (32'd1 << 24));
      2: return $signed(32'($urandom_range(0, 1 << 21)) - (32'd1 << 20));
      default: return $signed(32'($urandom_range(0, 8)) - 32'd4);
    endcase
  endfunction

  function automatic logic [31:0] rand_elem();
    if ($urandom_range(0, 9) == 0) begin
      return $urandom();
    end
    return 32'($urandom_range(0, 1 << 19)) - (32'd1 << 18);
  endfunction

  always @(posedge clk) begin
    vtx_out_t want;
    if (rst_n && out_valid) begin
      n_results++;
      if (out_div_by_zero) n_zero_w++;
      if (pending_vtx.size() == 0) begin
        $display("%0t: result with nothing expected: x=%0d y=%0d z=%0d w=%0d dz=%0b",
                 $time, out_x, out_y, out_z, out_w, out_div_by_zero);
        mismatches++;
      end else begin
        want = pending_vtx.pop_front();
        if (out_x !== want.x) begin
          $display("%0t: out_x expected %0d actual %0d", $time, want.x, out_x);
          mismatches++;
        end
        if (out_y !== want.y) begin
          $display("%0t: out_y expected %0d actual %0d", $time, want.y, out_y);
          mismatches++;
        end
        if (out_z !== want.z) begin
          $display("%0t: out_z expected %0d actual %0d", $time, want.z, out_z);
          mismatches++;
        end
        if (out_w !== want.w) begin
          $display("%0t: out_w expected %0d actual %0d", $time, want.w, out_w);
          mismatches++;
        end
        if (out_div_by_zero !== want.dz) begin
          $display("%0t: out_div_by_zero expected %0b actual %0b", $time, want.dz,
                   out_div_by_zero);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  stim_row_t directed [] = '{
    '{1'b0, 3'd0, 64'd0, REQ_POINT, 32'sh0001_0000, 32'sh0002_0000, -32'sh0003_0000,
      32'sh0001_0000, 1'b1, '{32'sh0001_0000, 32'sh0002_0000, -32'sh0003_0000, OneQ, 1'b0}},
    '{1'b0, 3'd0, 64'd0, REQ_POINT, 32'sh0005_0000, -32'sh0007_0000, 32'sh1234_5678,
      32'sh0, 1'b1, '{32'sh0, 32'sh0, 32'sh0, OneQ, 1'b1}},
    '{1'b0, 3'd0, 64'd0, REQ_POINT, SatMax, SatMin, 32'sh0, OneQ, 1'b1,
      '{SatMax, SatMin, 32'sh0, OneQ, 1'b0}},
    '{1'b0, 3'd0, 64'd0, REQ_DIR, SatMax, SatMin, -32'sd1, 32'sh7654_3210, 1'b1,
      '{SatMax, SatMin, -32'sd1, 32'sh0, 1'b0}},
    '{1'b0, 3'd0, 64'd0, REQ_DIR, 32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000, 32'sh0,
      1'b1, '{32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000, 32'sh0, 1'b0}},
    '{1'b0, 3'd0, 64'd0, REQ_POINT, 32'sh0002_0000, -32'sh0004_0000, 32'sd1,
      32'sh0002_0000, 1'b1, '{32'sh0001_0000, -32'sh0002_0000, 32'sh0, OneQ, 1'b0}},
    '{1'b0, 3'd0, 64'd0, REQ_POINT, SatMax, SatMin, 32'sh0, -32'sh0001_0000, 1'b1,
      '{-32'sh7fff_ffff, SatMax, 32'sh0, OneQ, 1'b0}},
    '{1'b0, 3'd0, 64'd0, REQ_POINT, 32'sh0001_0000, -32'sh0001_0000, 32'sh0, 32'sd1, 1'b1,
      '{SatMax, SatMin, 32'sh0, OneQ, 1'b0}},
    '{1'b0, 3'd0, 64'd0, REQ_POINT, 32'sh5555_5555, 32'shaaaa_aaaa, -32'sd1, -32'sd1, 1'b0,
      '{32'sh0, 32'sh0, 32'sh0, 32'sh0, 1'b0}},
    '{1'b0, 3'd0, 64'd0, REQ_POINT, SatMin, SatMin, SatMin, SatMin, 1'b0,
      '{32'sh0, 32'sh0, 32'sh0, 32'sh0, 1'b0}},
    '{1'b0, 3'd0, 64'd0, REQ_DIR, SatMin, SatMax, 32'sh0, SatMin, 1'b0,
      '{32'sh0, 32'sh0, 32'sh0, 32'sh0, 1'b0}},
    '{1'b1, 3'd7, {32'd1, 32'd0}, REQ_POINT, 32'sh0, 32'sh0, 32'sh0, 32'sh0, 1'b0,
      '{32'sh0, 32'sh0, 32'sh0, 32'sh0, 1'b0}},
    '{1'b0, 3'd0, 64'd0, REQ_POINT, 32'sh0005_0000, 32'sh0003_0000, 32'sh0001_0000,
      32'sd100, 1'b1, '{32'sh0, 32'sh0, 32'sh0, OneQ, 1'b1}},
    '{1'b0, 3'd0, 64'd0, REQ_POINT, 32'sh0005_0000, 32'sh0003_0000, 32'sh0001_0000,
      -32'sd100, 1'b0, '{32'sh0, 32'sh0, 32'sh0, 32'sh0, 1'b0}},
    '{1'b0, 3'd0, 64'd0, REQ_POINT, 32'sh0005_0000, -32'sh0003_0000, 32'sh0001_0000,
      32'sh0020_0000, 1'b0, '{32'sh0, 32'sh0, 32'sh0, 32'sh0, 1'b0}}
  };

  initial begin
    logic [CfgDataW-1:0] fill;
    int phase_items;
    req_t kind;
    logic signed [ElemW-1:0] wv;
    rst_n = 1'b0;
    start = 1'b0;
    in_req_type = 1'b0;
    in_x = '0;
    in_y = '0;
    in_z = '0;
    in_w = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    mismatches = 0;
    n_requests = 0;
    n_results = 0;
    n_zero_w = 0;
    cycles = 0;
    idle_gaps = 1'b1;
    matrix_regs[0] = 64'd65536;
    matrix_regs[1] = 64'd0;
    matrix_regs[2] = 64'd65536 << 32;
    matrix_regs[3] = 64'd0;
    matrix_regs[4] = 64'd0;
    matrix_regs[5] = 64'd65536;
    matrix_regs[6] = 64'd0;
    matrix_regs[7] = 64'd65536 << 32;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) begin
      if (directed[i].is_cfg) begin
        start <= 1'b0;
        drain_pipeline();
        write_reg(directed[i].idx, directed[i].data);
        cfg_valid <= 1'b0;
      end else begin
        send_vertex(directed[i].kind, directed[i].x, directed[i].y, directed[i].z,
                    directed[i].w, directed[i].has_exp, directed[i].exp);
      end
    end

    for (int phase = 0; phase < 8; phase++) begin
      start <= 1'b0;
      drain_pipeline();
      for (int r = 0; r < NumRegs; r++) begin
        case (phase)
          0: fill = '0;
          1: fill = '1;
          2: fill = 64'h8000_0000_8000_0000;
          3: fill = 64'h7fff_ffff_7fff_ffff;
          4: fill = {$urandom(), $urandom()};
          default: fill = {rand_elem(), rand_elem()};
        endcase
        write_reg(r[CfgIdxW-1:0], fill);
      end
      cfg_valid <= 1'b0;
      idle_gaps = (phase % 3) != 2;
      phase_items = (phase < 4) ? 120 : 270;
      for (int n = 0; n < phase_items; n++) begin
        kind = ($urandom_range(0, 3) == 0) ? REQ_DIR : REQ_POINT;
        wv = ($urandom_range(0, 15) == 0) ? 32'sh0 : rand_comp();
        send_vertex(kind, rand_comp(), rand_comp(), rand_comp(), wv, 1'b0, '0);
      end
    end
    start <= 1'b0;

    while (pending_vtx.size() != 0) @(posedge clk);
    repeat (LatencyCycles + 10) @(posedge clk);
    $display("Sent %0d vertex requests over 10 matrix settings, checked %0d results",
             n_requests, n_results);
    $display("(%0d with zero w), %0d mismatches.", n_zero_w, mismatches);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
